// File: hw/rtl/gnoise_pkg.sv
`default_nettype none

package gnoise_pkg;

  // Operation codes carried by the command channel.
  localparam logic [2:0] OP_LOAD_PERM = 3'd0;
  localparam logic [2:0] OP_LOAD_G1   = 3'd1;
  localparam logic [2:0] OP_LOAD_G2   = 3'd2;
  localparam logic [2:0] OP_LOAD_G3   = 3'd3;
  localparam logic [2:0] OP_EVAL_1D   = 3'd4;
  localparam logic [2:0] OP_EVAL_2D   = 3'd5;
  localparam logic [2:0] OP_EVAL_3D   = 3'd6;

  localparam int OP_W    = 3;
  localparam int INDEX_W = 12;
  localparam int PERM_W  = 12;
  localparam int GRAD_W  = 16;
  localparam int COORD_W = 32;
  localparam int NOISE_W = 18;

  // Position within a cell is Q0.16, the smooth weight needs one more bit.
  localparam int WEIGHT_FRAC = 16;
  localparam int S_W         = 17;
  // Corner offset (r or r - 1.0) as signed Q1.16.
  localparam int R_W         = 18;
  localparam int PROD_W      = R_W + GRAD_W;
  // Three products summed, with headroom.
  localparam int DOT_W       = 36;

  localparam int LATTICE_OFFSET = 4096;
  localparam int OUT_SHIFT      = 14;

  localparam logic signed [NOISE_W-1:0] NOISE_MAX = 18'sd131071;
  localparam logic signed [NOISE_W-1:0] NOISE_MIN = -18'sd131072;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [INDEX_W-1:0]        index;
    logic [PERM_W-1:0]         perm_value;
    logic signed [GRAD_W-1:0]  g0;
    logic signed [GRAD_W-1:0]  g1;
    logic signed [GRAD_W-1:0]  g2;
  } load_cmd_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] g0;
    logic signed [GRAD_W-1:0] g1;
    logic signed [GRAD_W-1:0] g2;
  } grad_vec_t;

endpackage

`default_nettype wire

// File: hw/rtl/gnoise_ram.sv
`default_nettype none

module gnoise_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire             clk,
  input  wire             we,
  input  wire [AW-1:0]    waddr,
  input  wire [WIDTH-1:0] wdata,
  input  wire             re,
  input  wire [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gnoise_axis.sv
`default_nettype none

// One coordinate axis: lattice cell and fraction in the first stage, the
// square of the fraction in the second, the smooth weight in the third.
module gnoise_axis #(
  parameter int FRAC_BITS = 16,
  parameter int IDX_W     = 12
) (
  input  wire                                   clk,
  input  wire                                   en,
  input  wire signed [gnoise_pkg::COORD_W-1:0]  coord,
  output logic [IDX_W-1:0]                      cell0,
  output logic [IDX_W-1:0]                      cell1,
  output logic [gnoise_pkg::WEIGHT_FRAC-1:0]    frac,
  output logic [gnoise_pkg::S_W-1:0]            smooth
);

  localparam int T_W = FRAC_BITS + IDX_W;
  localparam int RF  = gnoise_pkg::WEIGHT_FRAC;
  localparam logic [RF+1:0] THREE_ONE = (RF+2)'(3 * (1 << RF));

  logic [T_W-1:0]    t;
  logic [RF-1:0]     r_next;
  logic [2*RF-1:0]   sq;
  logic [RF-1:0]     frac_s2;
  logic [RF-1:0]     sq_hi;
  logic [RF+1:0]     weight;
  logic [2*RF+1:0]   wprod;

  // Only the bits up to the top of the cell index matter, so the sum is
  // taken modulo 2^(FRAC_BITS + IDX_W); the upper bits give floor for free.
  assign t = T_W'(coord) + (T_W'(gnoise_pkg::LATTICE_OFFSET) << FRAC_BITS);

  if (FRAC_BITS >= RF) begin : g_trunc
    assign r_next = t[FRAC_BITS-1 -: RF];
  end else begin : g_widen
    assign r_next = {t[FRAC_BITS-1:0], {(RF-FRAC_BITS){1'b0}}};
  end

  assign sq     = (2*RF)'(frac) * (2*RF)'(frac);
  assign weight = THREE_ONE - {1'b0, frac_s2, 1'b0};
  assign wprod  = (2*RF+2)'(sq_hi) * (2*RF+2)'(weight);

  always_ff @(posedge clk) begin
    if (en) begin
      cell0   <= t[T_W-1:FRAC_BITS];
      cell1   <= IDX_W'(t[T_W-1:FRAC_BITS] + 1'b1);
      frac    <= r_next;
      frac_s2 <= frac;
      sq_hi   <= sq[2*RF-1:RF];
      smooth  <= wprod[RF+gnoise_pkg::S_W-1:RF];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gnoise_tables.sv
`default_nettype none

// Table stages: permutation of the x cells, hashing with the y cells,
// gradient fetch with the z cells. Each lookup has its own copy of the
// table; a load is written into each copy as it passes that copy's stage,
// so every evaluation sees exactly the loads that came before it.
module gnoise_tables #(
  parameter int IDX_W = 12
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          en,
  input  wire                          valid,
  input  wire gnoise_pkg::load_cmd_t   cmd,
  input  wire [IDX_W-1:0]              x_cell0,
  input  wire [IDX_W-1:0]              x_cell1,
  input  wire [IDX_W-1:0]              y_cell0,
  input  wire [IDX_W-1:0]              y_cell1,
  input  wire [IDX_W-1:0]              z_cell0,
  input  wire [IDX_W-1:0]              z_cell1,
  output gnoise_pkg::grad_vec_t        grad [8]
);

  localparam int DEPTH = 2 ** IDX_W;
  localparam int G_W   = gnoise_pkg::GRAD_W;
  localparam int P_W   = gnoise_pkg::PERM_W;

  gnoise_pkg::load_cmd_t cmd_s2;
  gnoise_pkg::load_cmd_t cmd_s3;
  logic                  valid_s2;
  logic                  valid_s3;
  logic [2:0]            op_s4;

  logic [IDX_W-1:0] x_cell [2];
  logic [IDX_W-1:0] y_cell_s2 [2];
  logic [IDX_W-1:0] z_cell_s2 [2];
  logic [IDX_W-1:0] z_cell_s3 [2];
  logic [IDX_W-1:0] hash_b [4];
  logic [IDX_W-1:0] hash_g3 [8];

  logic [P_W-1:0]   perm_a [2];
  logic [P_W-1:0]   perm_b [4];
  logic [G_W-1:0]   g1_rd [2];
  logic [G_W-1:0]   g1_s4 [2];
  logic [2*G_W-1:0] g2_rd [4];
  logic [3*G_W-1:0] g3_rd [8];

  logic we_perm_a;
  logic we_perm_b;
  logic we_g1;
  logic we_g2;
  logic we_g3;

  assign x_cell[0] = x_cell0;
  assign x_cell[1] = x_cell1;

  assign we_perm_a = en && valid    && (cmd.op    == gnoise_pkg::OP_LOAD_PERM);
  assign we_perm_b = en && valid_s2 && (cmd_s2.op == gnoise_pkg::OP_LOAD_PERM);
  assign we_g1     = en && valid_s2 && (cmd_s2.op == gnoise_pkg::OP_LOAD_G1);
  assign we_g2     = en && valid_s3 && (cmd_s3.op == gnoise_pkg::OP_LOAD_G2);
  assign we_g3     = en && valid_s3 && (cmd_s3.op == gnoise_pkg::OP_LOAD_G3);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s2 <= 1'b0;
      valid_s3 <= 1'b0;
    end else if (en) begin
      valid_s2 <= valid;
      valid_s3 <= valid_s2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_s2       <= cmd;
      cmd_s3       <= cmd_s2;
      op_s4        <= cmd_s3.op;
      y_cell_s2[0] <= y_cell0;
      y_cell_s2[1] <= y_cell1;
      z_cell_s2[0] <= z_cell0;
      z_cell_s2[1] <= z_cell1;
      z_cell_s3    <= z_cell_s2;
      g1_s4        <= g1_rd;
    end
  end

  for (genvar n = 0; n < 2; n++) begin : g_perm_a
    gnoise_ram #(.WIDTH(P_W), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (we_perm_a),
      .waddr (IDX_W'(cmd.index)),
      .wdata (cmd.perm_value),
      .re    (en),
      .raddr (x_cell[n]),
      .rdata (perm_a[n])
    );
  end

  for (genvar n = 0; n < 4; n++) begin : g_perm_b
    assign hash_b[n] = IDX_W'(IDX_W'(perm_a[n % 2]) + y_cell_s2[n / 2]);
    gnoise_ram #(.WIDTH(P_W), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (we_perm_b),
      .waddr (IDX_W'(cmd_s2.index)),
      .wdata (cmd_s2.perm_value),
      .re    (en),
      .raddr (hash_b[n]),
      .rdata (perm_b[n])
    );
  end

  for (genvar n = 0; n < 2; n++) begin : g_grad1
    gnoise_ram #(.WIDTH(G_W), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (we_g1),
      .waddr (IDX_W'(cmd_s2.index)),
      .wdata (cmd_s2.g0),
      .re    (en),
      .raddr (IDX_W'(perm_a[n])),
      .rdata (g1_rd[n])
    );
  end

  for (genvar n = 0; n < 4; n++) begin : g_grad2
    gnoise_ram #(.WIDTH(2*G_W), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (we_g2),
      .waddr (IDX_W'(cmd_s3.index)),
      .wdata ({cmd_s3.g0, cmd_s3.g1}),
      .re    (en),
      .raddr (IDX_W'(perm_b[n])),
      .rdata (g2_rd[n])
    );
  end

  for (genvar n = 0; n < 8; n++) begin : g_grad3
    assign hash_g3[n] = IDX_W'(IDX_W'(perm_b[n % 4]) + z_cell_s3[n / 4]);
    gnoise_ram #(.WIDTH(3*G_W), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (we_g3),
      .waddr (IDX_W'(cmd_s3.index)),
      .wdata ({cmd_s3.g0, cmd_s3.g1, cmd_s3.g2}),
      .re    (en),
      .raddr (hash_g3[n]),
      .rdata (g3_rd[n])
    );
  end

  // Unused corners and components read as zero so that every mode shares
  // the same dot product and blend tree.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      grad[k] = '0;
      case (op_s4)
        gnoise_pkg::OP_EVAL_1D: begin
          if (k < 2) begin
            grad[k].g0 = g1_s4[k[0]];
          end
        end
        gnoise_pkg::OP_EVAL_2D: begin
          if (k < 4) begin
            grad[k].g0 = g2_rd[k[1:0]][2*G_W-1:G_W];
            grad[k].g1 = g2_rd[k[1:0]][G_W-1:0];
          end
        end
        default: begin
          grad[k].g0 = g3_rd[k][3*G_W-1:2*G_W];
          grad[k].g1 = g3_rd[k][2*G_W-1:G_W];
          grad[k].g2 = g3_rd[k][G_W-1:0];
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gnoise_lerp.sv
`default_nettype none

// One blend level over several lanes: difference, weighted product, sum.
module gnoise_lerp #(
  parameter int LANES = 4
) (
  input  wire                                  clk,
  input  wire                                  en,
  input  wire [gnoise_pkg::S_W-1:0]            smooth,
  input  wire signed [gnoise_pkg::DOT_W-1:0]   a [LANES],
  input  wire signed [gnoise_pkg::DOT_W-1:0]   b [LANES],
  output logic signed [gnoise_pkg::DOT_W-1:0] y [LANES]
);

  localparam int DW     = gnoise_pkg::DOT_W;
  localparam int DIFF_W = DW + 1;
  localparam int MUL_W  = gnoise_pkg::S_W + 1 + DIFF_W;

  logic [gnoise_pkg::S_W-1:0] s_d;
  logic signed [DIFF_W-1:0]   diff [LANES];
  logic signed [DW-1:0]       a_d [LANES];
  logic signed [DW-1:0]       a_m [LANES];
  logic signed [MUL_W-1:0]    prod [LANES];

  always_ff @(posedge clk) begin
    if (en) begin
      s_d <= smooth;
      for (int i = 0; i < LANES; i++) begin
        diff[i] <= DIFF_W'(b[i]) - DIFF_W'(a[i]);
        a_d[i]  <= a[i];
        prod[i] <= $signed({1'b0, s_d}) * diff[i];
        a_m[i]  <= a_d[i];
        // The blended value lies between a and b, so it fits again.
        y[i]    <= a_m[i] + DW'(prod[i] >>> gnoise_pkg::WEIGHT_FRAC);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gnoise_fifo.sv
`default_nettype none

// Two-entry result queue that decouples the pipeline from the receiver.
module gnoise_fifo #(
  parameter int WIDTH = 18
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire [WIDTH-1:0]  din,
  output logic             room,
  output logic             valid,
  input  wire              stall,
  output logic [WIDTH-1:0] dout
);

  logic [1:0]       count;
  logic [WIDTH-1:0] slot0;
  logic [WIDTH-1:0] slot1;
  logic             pop;

  assign pop   = (count != 2'd0) && !stall;
  assign room  = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign dout  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= (count == 2'd2) ? slot1 : din;
      if (push) begin
        slot1 <= din;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= din;
      end else begin
        slot1 <= din;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gradient_noise_1d_2d_3d.sv
// Lattice gradient noise in one, two or three dimensions.
// Command channel (cmd_valid / cmd_stall): each transaction either loads one
// permutation entry or one 1D, 2D or 3D gradient vector, and gives no result,
// or evaluates noise at a Q15.16 point and gives one saturated Q1.16 value.
// Operation seven is taken and dropped. Tables are not cleared at reset;
// load every entry an evaluation can reach before evaluating.
// Result channel (res_valid / res_stall) carries noise_value.
// Throughput is one transaction per cycle, sustained while the result queue
// has room: every table lookup of an evaluation has its own copy of the table,
// so no read port is shared. From the accepting edge to res_valid a result
// passes the input register, the three table stages, the two dot product
// stages, three blend levels of three stages each, the saturation register
// and the write into the result queue. A load and a later evaluation may
// follow each other back to back; the evaluation sees the load.
// Reset (rst, synchronous) empties the pipeline and the result queue. When
// the receiver stalls, results gather in a two-entry queue; the command side
// keeps accepting until the queue is full, then cmd_stall rises and the whole
// pipeline holds. Nothing is lost or repeated.
`default_nettype none

module gradient_noise_1d_2d_3d #(
  parameter int TABLE_SIZE = 4096,
  parameter int FRAC_BITS  = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cmd_valid,
  output logic                                 cmd_stall,
  input  wire [gnoise_pkg::OP_W-1:0]           operation,
  input  wire [gnoise_pkg::INDEX_W-1:0]        table_index,
  input  wire [gnoise_pkg::PERM_W-1:0]         perm_value,
  input  wire signed [gnoise_pkg::GRAD_W-1:0]  grad_first,
  input  wire signed [gnoise_pkg::GRAD_W-1:0]  grad_second,
  input  wire signed [gnoise_pkg::GRAD_W-1:0]  grad_third,
  input  wire signed [gnoise_pkg::COORD_W-1:0] coord_x,
  input  wire signed [gnoise_pkg::COORD_W-1:0] coord_y,
  input  wire signed [gnoise_pkg::COORD_W-1:0] coord_z,
  output logic                                 res_valid,
  input  wire                                  res_stall,
  output logic signed [gnoise_pkg::NOISE_W-1:0] noise_value
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int DW    = gnoise_pkg::DOT_W;
  localparam int RF    = gnoise_pkg::WEIGHT_FRAC;
  localparam int SW    = gnoise_pkg::S_W;
  localparam int NW    = gnoise_pkg::NOISE_W;

  // Pipeline advance: the whole datapath moves while the queue has room.
  logic en;
  logic fifo_room;

  logic [15:1] vld;
  logic [2:0]  op_p [1:15];
  logic        out_vld;

  gnoise_pkg::load_cmd_t cmd_s1;

  logic signed [gnoise_pkg::COORD_W-1:0] coord [3];
  logic [IDX_W-1:0] cell0 [3];
  logic [IDX_W-1:0] cell1 [3];
  logic [RF-1:0]    r_s1 [3];
  logic [RF-1:0]    r_s2 [3];
  logic [RF-1:0]    r_s3 [3];
  logic [RF-1:0]    r_s4 [3];
  logic [SW-1:0]    s_s3 [3];
  logic [SW-1:0]    sm_line [3][9];

  gnoise_pkg::grad_vec_t grad_s4 [8];

  logic signed [gnoise_pkg::PROD_W-1:0] prod_s5 [8][3];
  logic signed [DW-1:0] dot_s6 [8];

  logic signed [DW-1:0] xa [4];
  logic signed [DW-1:0] xb [4];
  logic signed [DW-1:0] xl [4];
  logic signed [DW-1:0] ya [2];
  logic signed [DW-1:0] yb [2];
  logic signed [DW-1:0] yl [2];
  logic signed [DW-1:0] za [1];
  logic signed [DW-1:0] zb [1];
  logic signed [DW-1:0] zl [1];
  logic signed [DW-1:0] xl_line [6];
  logic signed [DW-1:0] yl_line [3];

  logic signed [DW-1:0] pick;
  logic signed [DW-1:0] scaled;
  logic signed [NW-1:0] noise_next;
  logic signed [NW-1:0] noise_s16;

  assign en        = fifo_room;
  assign cmd_stall = !en;

  assign coord[0] = coord_x;
  assign coord[1] = coord_y;
  assign coord[2] = coord_z;

  // Valid bits travel alongside the data; only they need a reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld     <= {vld[14:1], cmd_valid};
      out_vld <= vld[15] && ((op_p[15] == gnoise_pkg::OP_EVAL_1D) ||
                             (op_p[15] == gnoise_pkg::OP_EVAL_2D) ||
                             (op_p[15] == gnoise_pkg::OP_EVAL_3D));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_s1.op         <= operation;
      cmd_s1.index      <= table_index;
      cmd_s1.perm_value <= perm_value;
      cmd_s1.g0         <= grad_first;
      cmd_s1.g1         <= grad_second;
      cmd_s1.g2         <= grad_third;
      op_p[1]           <= operation;
      for (int k = 2; k <= 15; k++) begin
        op_p[k] <= op_p[k-1];
      end
    end
  end

  // Cell, fraction and smooth weight of each axis.
  for (genvar a = 0; a < 3; a++) begin : g_axis
    gnoise_axis #(.FRAC_BITS(FRAC_BITS), .IDX_W(IDX_W)) u_axis (
      .clk    (clk),
      .en     (en),
      .coord  (coord[a]),
      .cell0  (cell0[a]),
      .cell1  (cell1[a]),
      .frac   (r_s1[a]),
      .smooth (s_s3[a])
    );
  end

  // The fraction is needed again at the dot products, the smooth weight of
  // each axis at the blend level for that axis.
  always_ff @(posedge clk) begin
    if (en) begin
      r_s2 <= r_s1;
      r_s3 <= r_s2;
      r_s4 <= r_s3;
      for (int a = 0; a < 3; a++) begin
        sm_line[a][0] <= s_s3[a];
        for (int k = 1; k < 9; k++) begin
          sm_line[a][k] <= sm_line[a][k-1];
        end
      end
    end
  end

  gnoise_tables #(.IDX_W(IDX_W)) u_tables (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .valid   (vld[1]),
    .cmd     (cmd_s1),
    .x_cell0 (cell0[0]),
    .x_cell1 (cell1[0]),
    .y_cell0 (cell0[1]),
    .y_cell1 (cell1[1]),
    .z_cell0 (cell0[2]),
    .z_cell1 (cell1[2]),
    .grad    (grad_s4)
  );

  // Corner k takes the far side of axis d when bit d of k is set; the far
  // offset r - 1.0 is r with the top two bits set.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++) begin
        prod_s5[k][0] <= $signed({k[0] ? 2'b11 : 2'b00, r_s4[0]}) * grad_s4[k].g0;
        prod_s5[k][1] <= $signed({k[1] ? 2'b11 : 2'b00, r_s4[1]}) * grad_s4[k].g1;
        prod_s5[k][2] <= $signed({k[2] ? 2'b11 : 2'b00, r_s4[2]}) * grad_s4[k].g2;
        dot_s6[k]     <= DW'(prod_s5[k][0]) + DW'(prod_s5[k][1]) + DW'(prod_s5[k][2]);
      end
    end
  end

  for (genvar m = 0; m < 4; m++) begin : g_xin
    assign xa[m] = dot_s6[2*m];
    assign xb[m] = dot_s6[2*m+1];
  end

  gnoise_lerp #(.LANES(4)) u_lerp_x (
    .clk    (clk),
    .en     (en),
    .smooth (sm_line[0][2]),
    .a      (xa),
    .b      (xb),
    .y      (xl)
  );

  for (genvar m = 0; m < 2; m++) begin : g_yin
    assign ya[m] = xl[2*m];
    assign yb[m] = xl[2*m+1];
  end

  gnoise_lerp #(.LANES(2)) u_lerp_y (
    .clk    (clk),
    .en     (en),
    .smooth (sm_line[1][5]),
    .a      (ya),
    .b      (yb),
    .y      (yl)
  );

  assign za[0] = yl[0];
  assign zb[0] = yl[1];

  gnoise_lerp #(.LANES(1)) u_lerp_z (
    .clk    (clk),
    .en     (en),
    .smooth (sm_line[2][8]),
    .a      (za),
    .b      (zb),
    .y      (zl)
  );

  // The 1D and 2D answers are ready earlier and wait for the 3D one.
  always_ff @(posedge clk) begin
    if (en) begin
      xl_line[0] <= xl[0];
      for (int k = 1; k < 6; k++) begin
        xl_line[k] <= xl_line[k-1];
      end
      yl_line[0] <= yl[0];
      for (int k = 1; k < 3; k++) begin
        yl_line[k] <= yl_line[k-1];
      end
      noise_s16 <= noise_next;
    end
  end

  always_comb begin
    case (op_p[15])
      gnoise_pkg::OP_EVAL_1D: pick = xl_line[5];
      gnoise_pkg::OP_EVAL_2D: pick = yl_line[2];
      default:                pick = zl[0];
    endcase
    scaled = pick >>> gnoise_pkg::OUT_SHIFT;
    if (scaled > DW'(gnoise_pkg::NOISE_MAX)) begin
      noise_next = gnoise_pkg::NOISE_MAX;
    end else if (scaled < DW'(gnoise_pkg::NOISE_MIN)) begin
      noise_next = gnoise_pkg::NOISE_MIN;
    end else begin
      noise_next = NW'(scaled);
    end
  end

  gnoise_fifo #(.WIDTH(NW)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (en && out_vld),
    .din   (noise_s16),
    .room  (fifo_room),
    .valid (res_valid),
    .stall (res_stall),
    .dout  (noise_value)
  );

endmodule

`default_nettype wire

// File: tb/sv/gradient_noise_1d_2d_3d_tb.sv
`timescale 1ns / 100ps
`default_nettype none

// Testbench for the lattice gradient noise block.
// An initial block builds transactions in a queue. A clocked driver presents
// them on the command channel, and a clocked monitor checks every result
// against a noise predictor of its own, held in this module.
module gradient_noise_1d_2d_3d_tb;

  // Operation seven has no name in the package; the block drops it.
  localparam logic [gnoise_pkg::OP_W-1:0] OP_IGNORED = 3'd7;
  localparam int TBL = 4096;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [gnoise_pkg::OP_W-1:0]           op;
    logic [gnoise_pkg::INDEX_W-1:0]        idx;
    logic [gnoise_pkg::PERM_W-1:0]         pv;
    logic signed [gnoise_pkg::GRAD_W-1:0]  ga, gb, gc;
    logic signed [gnoise_pkg::COORD_W-1:0] cx, cy, cz;
  } noise_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  logic [gnoise_pkg::OP_W-1:0] operation = '0;
  logic [gnoise_pkg::INDEX_W-1:0] table_index = '0;
  logic [gnoise_pkg::PERM_W-1:0] perm_value = '0;
  logic signed [gnoise_pkg::GRAD_W-1:0] grad_first = '0, grad_second = '0;
  logic signed [gnoise_pkg::GRAD_W-1:0] grad_third = '0;
  logic signed [gnoise_pkg::COORD_W-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic signed [gnoise_pkg::NOISE_W-1:0] noise_value;

  gradient_noise_1d_2d_3d i_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .operation(operation), .table_index(table_index), .perm_value(perm_value),
    .grad_first(grad_first), .grad_second(grad_second), .grad_third(grad_third),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .res_valid(res_valid), .res_stall(res_stall), .noise_value(noise_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Transactions waiting to be driven, and noise values still to arrive.
  noise_cmd_t cmd_q[$];
  logic signed [gnoise_pkg::NOISE_W-1:0] noise_due_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit hold_cmds = 1'b0;
  int errors = 0;
  int unsigned cycles = 0;
  int unsigned queued = 0;
  bit cmd_took = 1'b0;

  // The predictor's own copy of the four tables, written as loads are accepted.
  logic [gnoise_pkg::PERM_W-1:0]        pr_perm[TBL];
  logic signed [gnoise_pkg::GRAD_W-1:0] pr_g1[TBL];
  logic signed [gnoise_pkg::GRAD_W-1:0] pr_g2a[TBL], pr_g2b[TBL];
  logic signed [gnoise_pkg::GRAD_W-1:0] pr_g3a[TBL], pr_g3b[TBL], pr_g3c[TBL];

  // The generator keeps its own record of what has been loaded. An evaluation
  // is only queued once every entry it can reach has been written, because
  // the block's tables come out of reset with no defined contents.
  bit                            gen_perm_set[TBL];
  logic [gnoise_pkg::PERM_W-1:0] gen_perm[TBL];
  bit                            gen_g1_set[TBL], gen_g2_set[TBL], gen_g3_set[TBL];

  // Lattice cell of one coordinate after the 4096 offset, modulo the table.
  function automatic int cell_of(logic signed [gnoise_pkg::COORD_W-1:0] raw);
    longint t;
    t = longint'(raw) + (longint'(gnoise_pkg::LATTICE_OFFSET) <<< 16);
    return int'((t >>> 16) & (TBL - 1));
  endfunction

  function automatic longint blend(longint s, longint a, longint b);
    return a + ((s * (b - a)) >>> 16);
  endfunction

  function automatic longint dot2(int h, longint rx, longint ry);
    return rx * longint'(pr_g2a[h]) + ry * longint'(pr_g2b[h]);
  endfunction

  function automatic longint dot3(int h, longint rx, longint ry, longint rz);
    return rx * longint'(pr_g3a[h]) + ry * longint'(pr_g3b[h])
         + rz * longint'(pr_g3c[h]);
  endfunction

  function automatic logic signed [gnoise_pkg::NOISE_W-1:0] predict_noise(noise_cmd_t c);
    logic signed [gnoise_pkg::COORD_W-1:0] raw[3];
    longint t, r, r2, val, a, b, lo, hi;
    longint r0[3], r1[3], s[3];
    int c0[3], c1[3];
    int i, j, b00, b10, b01, b11;
    raw[0] = c.cx;
    raw[1] = c.cy;
    raw[2] = c.cz;
    for (int k = 0; k < 3; k++) begin
      t = longint'(raw[k]) + (longint'(gnoise_pkg::LATTICE_OFFSET) <<< 16);
      r = t & 65535;
      c0[k] = cell_of(raw[k]);
      c1[k] = (c0[k] + 1) % TBL;
      r0[k] = r;
      r1[k] = r - 65536;
      r2 = (r * r) >> 16;
      s[k] = (r2 * (3 * 65536 - 2 * r)) >> 16;
    end
    i = int'(pr_perm[c0[0]]);
    j = int'(pr_perm[c1[0]]);
    if (c.op == gnoise_pkg::OP_EVAL_1D) begin
      val = blend(s[0], r0[0] * longint'(pr_g1[i]), r1[0] * longint'(pr_g1[j]));
    end else begin
      b00 = int'(pr_perm[(i + c0[1]) % TBL]);
      b10 = int'(pr_perm[(j + c0[1]) % TBL]);
      b01 = int'(pr_perm[(i + c1[1]) % TBL]);
      b11 = int'(pr_perm[(j + c1[1]) % TBL]);
      if (c.op == gnoise_pkg::OP_EVAL_2D) begin
        a = blend(s[0], dot2(b00, r0[0], r0[1]), dot2(b10, r1[0], r0[1]));
        b = blend(s[0], dot2(b01, r0[0], r1[1]), dot2(b11, r1[0], r1[1]));
        val = blend(s[1], a, b);
      end else begin
        a = blend(s[0], dot3((b00 + c0[2]) % TBL, r0[0], r0[1], r0[2]),
                        dot3((b10 + c0[2]) % TBL, r1[0], r0[1], r0[2]));
        b = blend(s[0], dot3((b01 + c0[2]) % TBL, r0[0], r1[1], r0[2]),
                        dot3((b11 + c0[2]) % TBL, r1[0], r1[1], r0[2]));
        lo = blend(s[1], a, b);
        a = blend(s[0], dot3((b00 + c1[2]) % TBL, r0[0], r0[1], r1[2]),
                        dot3((b10 + c1[2]) % TBL, r1[0], r0[1], r1[2]));
        b = blend(s[0], dot3((b01 + c1[2]) % TBL, r0[0], r1[1], r1[2]),
                        dot3((b11 + c1[2]) % TBL, r1[0], r1[1], r1[2]));
        hi = blend(s[1], a, b);
        val = blend(s[2], lo, hi);
      end
    end
    val = val >>> gnoise_pkg::OUT_SHIFT;
    if (val > longint'(gnoise_pkg::NOISE_MAX)) val = longint'(gnoise_pkg::NOISE_MAX);
    if (val < longint'(gnoise_pkg::NOISE_MIN)) val = longint'(gnoise_pkg::NOISE_MIN);
    return gnoise_pkg::NOISE_W'(val);
  endfunction

  // Applies one accepted transaction to the predictor's tables, or records
  // the noise value that it must produce.
  task automatic absorb_cmd(noise_cmd_t c);
    case (c.op)
      gnoise_pkg::OP_LOAD_PERM: pr_perm[c.idx] = c.pv;
      gnoise_pkg::OP_LOAD_G1:   pr_g1[c.idx] = c.ga;
      gnoise_pkg::OP_LOAD_G2: begin
        pr_g2a[c.idx] = c.ga;
        pr_g2b[c.idx] = c.gb;
      end
      gnoise_pkg::OP_LOAD_G3: begin
        pr_g3a[c.idx] = c.ga;
        pr_g3b[c.idx] = c.gb;
        pr_g3c[c.idx] = c.gc;
      end
      gnoise_pkg::OP_EVAL_1D, gnoise_pkg::OP_EVAL_2D, gnoise_pkg::OP_EVAL_3D:
        noise_due_q.push_back(predict_noise(c));
      default: ;
    endcase
  endtask

  // Every transaction goes through here, so that the total sent is counted.
  task automatic enqueue(noise_cmd_t c);
    cmd_q.push_back(c);
    queued++;
  endtask

  function automatic logic signed [gnoise_pkg::GRAD_W-1:0] rand_grad();
    return gnoise_pkg::GRAD_W'(int'($urandom_range(32768)) - 16384);
  endfunction

  // Every field random within its range, so that each bit of each port moves.
  function automatic noise_cmd_t rand_fields(logic [gnoise_pkg::OP_W-1:0] op);
    noise_cmd_t c;
    c.op = op;
    c.idx = gnoise_pkg::INDEX_W'($urandom);
    c.pv = gnoise_pkg::PERM_W'($urandom);
    c.ga = rand_grad();
    c.gb = rand_grad();
    c.gc = rand_grad();
    c.cx = $urandom;
    c.cy = $urandom;
    c.cz = $urandom;
    return c;
  endfunction

  task automatic push_load(logic [gnoise_pkg::OP_W-1:0] op, int idx, int pv,
                           logic signed [gnoise_pkg::GRAD_W-1:0] ga,
                           logic signed [gnoise_pkg::GRAD_W-1:0] gb,
                           logic signed [gnoise_pkg::GRAD_W-1:0] gc);
    noise_cmd_t c;
    c = rand_fields(op);
    c.idx = gnoise_pkg::INDEX_W'(idx);
    c.pv = gnoise_pkg::PERM_W'(pv);
    c.ga = ga;
    c.gb = gb;
    c.gc = gc;
    case (op)
      gnoise_pkg::OP_LOAD_PERM: begin
        gen_perm_set[idx] = 1'b1;
        gen_perm[idx] = gnoise_pkg::PERM_W'(pv);
      end
      gnoise_pkg::OP_LOAD_G1: gen_g1_set[idx] = 1'b1;
      gnoise_pkg::OP_LOAD_G2: gen_g2_set[idx] = 1'b1;
      gnoise_pkg::OP_LOAD_G3: gen_g3_set[idx] = 1'b1;
      default: ;
    endcase
    enqueue(c);
  endtask

  task automatic need_perm(int idx);
    if (!gen_perm_set[idx])
      push_load(gnoise_pkg::OP_LOAD_PERM, idx, int'($urandom_range(TBL - 1)),
                rand_grad(), rand_grad(), rand_grad());
  endtask

  task automatic need_grad(logic [gnoise_pkg::OP_W-1:0] op, int idx);
    bit have;
    have = (op == gnoise_pkg::OP_LOAD_G1) ? gen_g1_set[idx]
         : (op == gnoise_pkg::OP_LOAD_G2) ? gen_g2_set[idx] : gen_g3_set[idx];
    if (!have) push_load(op, idx, int'($urandom), rand_grad(), rand_grad(), rand_grad());
  endtask

  // Queues an evaluation, preceded by loads of whatever entries it reaches
  // that have not yet been written.
  task automatic push_eval(logic [gnoise_pkg::OP_W-1:0] op,
                           logic signed [gnoise_pkg::COORD_W-1:0] x,
                           logic signed [gnoise_pkg::COORD_W-1:0] y,
                           logic signed [gnoise_pkg::COORD_W-1:0] z);
    noise_cmd_t c;
    int xc[2], yc[2], zc;
    int i, h;
    xc[0] = cell_of(x);
    xc[1] = (xc[0] + 1) % TBL;
    yc[0] = cell_of(y);
    yc[1] = (yc[0] + 1) % TBL;
    need_perm(xc[0]);
    need_perm(xc[1]);
    for (int a = 0; a < 2; a++) begin
      i = int'(gen_perm[xc[a]]);
      if (op == gnoise_pkg::OP_EVAL_1D) begin
        need_grad(gnoise_pkg::OP_LOAD_G1, i);
      end else begin
        for (int b = 0; b < 2; b++) begin
          h = (i + yc[b]) % TBL;
          need_perm(h);
          if (op == gnoise_pkg::OP_EVAL_2D) begin
            need_grad(gnoise_pkg::OP_LOAD_G2, int'(gen_perm[h]));
          end else begin
            zc = cell_of(z);
            need_grad(gnoise_pkg::OP_LOAD_G3, (int'(gen_perm[h]) + zc) % TBL);
            need_grad(gnoise_pkg::OP_LOAD_G3, (int'(gen_perm[h]) + zc + 1) % TBL);
          end
        end
      end
    end
    c = rand_fields(op);
    c.cx = x;
    c.cy = y;
    c.cz = z;
    enqueue(c);
  endtask

  // Mostly points near the origin, where cells get reused; the rest spread
  // over the whole coordinate range.
  function automatic logic signed [gnoise_pkg::COORD_W-1:0] rand_coord();
    if ($urandom_range(99) < 60)
      return gnoise_pkg::COORD_W'(int'($urandom_range(16 * 65536)) - 8 * 65536);
    return $urandom;
  endfunction

  // Queues about count transactions, the loads that evaluations need included.
  task automatic push_random(int unsigned count);
    int roll;
    int unsigned target;
    logic [gnoise_pkg::OP_W-1:0] op;
    target = queued + count;
    while (queued < target) begin
      roll = int'($urandom_range(99));
      if (roll < 4) begin
        enqueue(rand_fields(OP_IGNORED));
      end else if (roll < 20) begin
        op = gnoise_pkg::OP_W'($urandom_range(gnoise_pkg::OP_LOAD_G3,
                                              gnoise_pkg::OP_LOAD_PERM));
        push_load(op, int'($urandom_range(TBL - 1)), int'($urandom),
                  rand_grad(), rand_grad(), rand_grad());
      end else begin
        op = gnoise_pkg::OP_W'($urandom_range(gnoise_pkg::OP_EVAL_3D,
                                              gnoise_pkg::OP_EVAL_1D));
        push_eval(op, rand_coord(), rand_coord(), rand_coord());
      end
    end
  endtask

  task automatic wait_sent();
    while (cmd_q.size() != 0 || cmd_valid) @(posedge clk);
  endtask

  // Driver: a new transaction may be presented only once the current one has
  // been taken, so a stalled payload never changes.
  always @(posedge clk) begin
    cmd_took = cmd_valid && !cmd_stall && !rst;
    if (cmd_took) begin
      absorb_cmd('{op: operation, idx: table_index, pv: perm_value,
                   ga: grad_first, gb: grad_second, gc: grad_third,
                   cx: coord_x, cy: coord_y, cz: coord_z});
    end
  end

  always @(negedge clk) begin
    noise_cmd_t c;
    if (!rst && (!cmd_valid || cmd_took)) begin
      if (hold_cmds || cmd_q.size() == 0 || $urandom_range(99) < send_idle_pct) begin
        cmd_valid <= 1'b0;
      end else begin
        c = cmd_q.pop_front();
        operation <= c.op;
        table_index <= c.idx;
        perm_value <= c.pv;
        grad_first <= c.ga;
        grad_second <= c.gb;
        grad_third <= c.gc;
        coord_x <= c.cx;
        coord_y <= c.cy;
        coord_z <= c.cz;
        cmd_valid <= 1'b1;
      end
    end
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // Monitor: each noise value taken is matched with the oldest one due.
  always @(posedge clk) begin
    logic signed [gnoise_pkg::NOISE_W-1:0] due;
    if (!rst && res_valid && !res_stall) begin
      if (noise_due_q.size() == 0) begin
        $error("noise_value: unexpected result %0d", noise_value);
        errors++;
      end else begin
        due = noise_due_q.pop_front();
        if (noise_value !== due) begin
          $error("noise_value: expected %0d, actual %0d", due, noise_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: table edges, the extreme values the bench draws for each
    // field, the ignored operation, and points far below zero.
    push_load(gnoise_pkg::OP_LOAD_PERM, 0, TBL - 1, 16'sd16384, -16'sd16384, 16'sd16384);
    push_load(gnoise_pkg::OP_LOAD_PERM, TBL - 1, 0, -16'sd16384, 16'sd16384, -16'sd16384);
    push_load(gnoise_pkg::OP_LOAD_G1, TBL - 1, 0, -16'sd16384, 16'sd0, 16'sd0);
    push_load(gnoise_pkg::OP_LOAD_G2, 0, TBL - 1, 16'sd16384, -16'sd16384, 16'sd0);
    push_load(gnoise_pkg::OP_LOAD_G3, TBL - 1, 0, 16'sd16384, 16'sd16384, 16'sd16384);
    push_load(gnoise_pkg::OP_LOAD_G3, 0, 0, -16'sd16384, -16'sd16384, -16'sd16384);
    enqueue(rand_fields(OP_IGNORED));
    push_eval(gnoise_pkg::OP_EVAL_1D, 32'sd0, 32'sd0, 32'sd0);
    push_eval(gnoise_pkg::OP_EVAL_2D, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0);
    push_eval(gnoise_pkg::OP_EVAL_3D, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    // Cell 4095, where the upper neighbour wraps round to cell zero.
    push_eval(gnoise_pkg::OP_EVAL_1D, -32'sd1, -32'sd32768, 32'sd0);
    push_eval(gnoise_pkg::OP_EVAL_2D, -32'sd65536, -32'sd1, 32'sd0);
    push_eval(gnoise_pkg::OP_EVAL_3D, -32'sd1, -32'sd65535, -32'sd32768);
    // Negative points away from the wrap must floor, not truncate.
    push_eval(gnoise_pkg::OP_EVAL_3D, -32'sd212992, 32'sd163840, -32'sd98304);
    push_eval(gnoise_pkg::OP_EVAL_2D, -32'sd400000000, -32'sd123457, 32'sd0);
    push_eval(gnoise_pkg::OP_EVAL_1D, -32'sd2000000000, 32'sd0, 32'sd0);
    push_eval(gnoise_pkg::OP_EVAL_3D, 32'sd32768, 32'sd32768, 32'sd32768);
    wait_sent();

    // Random phases with varied idling on both sides; the first and the last idle on neither.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        3: begin send_idle_pct = 20; stall_pct = 20; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      push_random(340);
      wait_sent();
      if (ph == 2) begin
        // Let the pipeline run dry before the sender carries on.
        hold_cmds = 1'b1;
        while (noise_due_q.size() != 0) @(posedge clk);
        hold_cmds = 1'b0;
      end
    end

    stall_pct = 0;
    while (noise_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/gnoise_pkg.sv
hw/rtl/gnoise_ram.sv
hw/rtl/gnoise_axis.sv
hw/rtl/gnoise_tables.sv
hw/rtl/gnoise_lerp.sv
hw/rtl/gnoise_fifo.sv
hw/rtl/gradient_noise_1d_2d_3d.sv
tb/sv/gradient_noise_1d_2d_3d_tb.sv
